>>> sv/gcdl_pkg.sv
// types and constants shared by the gcd / lcm unit
package gcdl_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef struct packed {
    logic                  func;
    logic [DATA_WIDTH-1:0] first_operand;
    logic [DATA_WIDTH-1:0] second_operand;
  } gcdl_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  ok;
  } gcdl_rsp_t;

  typedef struct packed {
    logic                    mul;
    logic [2*DATA_WIDTH-1:0] acc;
    logic [DATA_WIDTH-1:0]   shreg;
    logic [DATA_WIDTH-1:0]   operand;
  } gcdl_step_in_t;

  typedef struct packed {
    logic [2*DATA_WIDTH-1:0] acc;
    logic [DATA_WIDTH-1:0]   shreg;
  } gcdl_step_out_t;

  localparam logic FUNC_GCD = 1'b0;
  localparam logic FUNC_LCM = 1'b1;

endpackage

>>> sv/gcd_lcm_unit.sv
// top level of the gcd / lcm unit
//
// request channel: req_valid, req_stall, req (func, first_operand, second_operand).
// response channel: rsp_valid, rsp_stall, rsp (value, ok).
// a transaction happens on a rising edge with valid high and stall low.
// func 0 returns the gcd of the two operands, func 1 the lcm; an lcm that does
// not fit in 32 bits returns value 0 with ok low, a zero operand gives lcm 0.
// one request is worked at a time on a shared one-bit-per-cycle divide /
// multiply step, so req_stall stays high from acceptance until the result
// moves to the output register.
// gcd runs one euclid remainder step, a full divide, per loop pass, at most
// about 47 steps for 32-bit operands; lcm then adds a quotient divide and a
// shift-add multiply; a zero lcm operand goes straight to the result.
// the output register lets the next request be accepted while a result waits.
// a stalled response holds its payload; the unit then finishes its current
// request and waits until the output register frees.
// reset empties the output register and returns the sequencer to idle.
module gcd_lcm_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  gcdl_pkg::gcdl_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output gcdl_pkg::gcdl_rsp_t rsp
);
  import gcdl_pkg::*;

  logic      busy;
  logic      res_valid;
  gcdl_rsp_t res;
  logic      res_take;

  gcdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign req_stall = busy;
  assign res_take  = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule

>>> sv/gcdl_step.sv
// shared one-bit divide / multiply step: restoring divide or shift-add multiply
module gcdl_step (
  input  gcdl_pkg::gcdl_step_in_t  step_in,
  output gcdl_pkg::gcdl_step_out_t step_out
);
  import gcdl_pkg::*;

  logic [DATA_WIDTH:0]     trial;
  logic [DATA_WIDTH:0]     diff;
  logic                    fits;
  logic [2*DATA_WIDTH-1:0] addend;

  always_comb begin
    trial  = {step_in.acc[DATA_WIDTH-1:0], step_in.shreg[DATA_WIDTH-1]};
    diff   = trial - {1'b0, step_in.operand};
    fits   = ~diff[DATA_WIDTH];
    addend = {{DATA_WIDTH{1'b0}},
              (step_in.shreg[DATA_WIDTH-1] ? step_in.operand : {DATA_WIDTH{1'b0}})};
    if (step_in.mul) begin
      step_out.acc   = {step_in.acc[2*DATA_WIDTH-2:0], 1'b0} + addend;
      step_out.shreg = {step_in.shreg[DATA_WIDTH-2:0], 1'b0};
    end else begin
      step_out.acc   = {{DATA_WIDTH{1'b0}},
                        (fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0])};
      step_out.shreg = {step_in.shreg[DATA_WIDTH-2:0], fits};
    end
  end

endmodule

>>> sv/gcdl_ctrl.sv
// sequencer: euclid remainder loop, quotient and product on the shared step unit
module gcdl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  gcdl_pkg::gcdl_req_t req,
  output logic                busy,
  output logic                res_valid,
  output gcdl_pkg::gcdl_rsp_t res,
  input  logic                res_take
);
  import gcdl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EUCLID,
    ST_DIV_R,
    ST_DIV_Q,
    ST_MUL,
    ST_DONE
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  state_t                  state;
  logic                    func;
  logic [DATA_WIDTH-1:0]   a_reg;
  logic [DATA_WIDTH-1:0]   b_reg;
  logic [DATA_WIDTH-1:0]   orig_a;
  logic [DATA_WIDTH-1:0]   orig_b;
  logic [2*DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0]   shreg;
  logic [CNT_W-1:0]        cnt;
  gcdl_step_in_t           step_in;
  gcdl_step_out_t          step_out;

  gcdl_step u_step (
    .step_in  (step_in),
    .step_out (step_out)
  );

  always_comb begin
    step_in.mul     = (state == ST_MUL);
    step_in.acc     = acc;
    step_in.shreg   = shreg;
    step_in.operand = (state == ST_MUL) ? orig_b : b_reg;
  end

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            func   <= req.func;
            a_reg  <= req.first_operand;
            b_reg  <= req.second_operand;
            orig_a <= req.first_operand;
            orig_b <= req.second_operand;
            if (req.func == FUNC_LCM &&
                (req.first_operand == '0 || req.second_operand == '0)) begin
              res.value <= '0;
              res.ok    <= 1'b1;
              state     <= ST_DONE;
            end else begin
              state <= ST_EUCLID;
            end
          end
        end
        ST_EUCLID: begin
          cnt <= '0;
          acc <= '0;
          if (b_reg == '0) begin
            if (func == FUNC_GCD) begin
              res.value <= a_reg;
              res.ok    <= 1'b1;
              state     <= ST_DONE;
            end else begin
              // divide the first operand by the gcd
              shreg <= orig_a;
              b_reg <= a_reg;
              state <= ST_DIV_Q;
            end
          end else begin
            shreg <= a_reg;
            state <= ST_DIV_R;
          end
        end
        ST_DIV_R: begin
          acc   <= step_out.acc;
          shreg <= step_out.shreg;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            a_reg <= b_reg;
            b_reg <= step_out.acc[DATA_WIDTH-1:0];
            state <= ST_EUCLID;
          end
        end
        ST_DIV_Q: begin
          acc   <= step_out.acc;
          shreg <= step_out.shreg;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            acc   <= '0;
            cnt   <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc   <= step_out.acc;
          shreg <= step_out.shreg;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            if (step_out.acc[2*DATA_WIDTH-1:DATA_WIDTH] == '0) begin
              res.value <= step_out.acc[DATA_WIDTH-1:0];
              res.ok    <= 1'b1;
            end else begin
              res.value <= '0;
              res.ok    <= 1'b0;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/gcdl_checker.sv
// port checker for the gcd / lcm unit and its bind
module gcdl_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input gcdl_pkg::gcdl_req_t req,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input gcdl_pkg::gcdl_rsp_t rsp
);
  import gcdl_pkg::*;

  // response held while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed under stall");

  // idle and empty right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !req_stall && !rsp_valid)
    else $error("not idle after reset");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted without going busy");

  // lcm overflow forces a zero value
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.value == '0)
    else $error("overflow response carries a nonzero value");

endmodule

bind gcd_lcm_unit gcdl_checker u_gcdl_checker (.*);
